[hdl/srtf_pkg.sv]
package srtf_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int SLOT_W        = 4;
    localparam int BURST_W       = 16;
    localparam int WAIT_W        = 20;
    localparam int STAT_W        = 3;
    localparam int REQ_W         = 2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_ARRIVAL = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ADMITTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_RAN      = 3'd2,
        ST_FINISHED = 3'd3,
        ST_IDLE_TCK = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_SEARCH = 1'b1
    } fsm_t;

    // command broadcast to every cell
    typedef struct packed {
        logic               clear;
        logic               load;
        logic               tick;
        logic [SLOT_W-1:0]  sel;
        logic [BURST_W-1:0] burst;
    } cell_cmd_t;

    // minimum-search wave handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [BURST_W-1:0] best;
        logic [SLOT_W-1:0]  idx;
    } wave_t;

endpackage

[hdl/srtf_cell.sv]
module srtf_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srtf_pkg::cell_cmd_t                 cmd,
    input  srtf_pkg::wave_t                     wave_in,
    output srtf_pkg::wave_t                     wave_out,
    output logic [srtf_pkg::BURST_W-1:0]        rem,
    output logic [srtf_pkg::BURST_W-1:0]        served,
    output logic [srtf_pkg::WAIT_W-1:0]         waited
);

    localparam logic [srtf_pkg::SLOT_W-1:0] MY_IDX = srtf_pkg::SLOT_W'(IDX);

    logic [srtf_pkg::BURST_W-1:0] rem_reg, rem_next;
    logic [srtf_pkg::BURST_W-1:0] served_reg, served_next;
    logic [srtf_pkg::WAIT_W-1:0]  waited_reg, waited_next;
    srtf_pkg::wave_t              wave_reg, wave_next;
    logic                         mine;

    assign mine = (cmd.sel == MY_IDX);

    always_comb
    begin
        rem_next    = rem_reg;
        served_next = served_reg;
        waited_next = waited_reg;
        if (cmd.clear)
        begin
            rem_next    = '0;
            served_next = '0;
            waited_next = '0;
        end
        else if (cmd.load && mine)
        begin
            rem_next    = cmd.burst;
            served_next = '0;
            waited_next = '0;
        end
        else if (cmd.tick)
        begin
            if (mine)
            begin
                rem_next    = rem_reg - 1'b1;
                served_next = served_reg + 1'b1;
            end
            else if (rem_reg != '0 && waited_reg != srtf_pkg::WAIT_MAX)
            begin
                waited_next = waited_reg + 1'b1;
            end
        end
    end

    // strict less-than keeps the lower slot on a tie
    always_comb
    begin
        wave_next = wave_in;
        if (rem_reg != '0 && (!wave_in.valid || rem_reg < wave_in.best))
        begin
            wave_next.valid = 1'b1;
            wave_next.best  = rem_reg;
            wave_next.idx   = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            served_reg <= '0;
            waited_reg <= '0;
            wave_reg   <= '0;
        end
        else
        begin
            rem_reg    <= rem_next;
            served_reg <= served_next;
            waited_reg <= waited_next;
            wave_reg   <= wave_next;
        end
    end

    assign wave_out = wave_reg;
    assign rem      = rem_reg;
    assign served   = served_reg;
    assign waited   = waited_reg;

endmodule

[hdl/srtf_preemptive_scheduler.sv]
// shortest-remaining-time-first job scheduler over a row of slot cells
//
// command channel: a beat is taken on a rising edge with start high and busy
// low; req_type selects arrival, tick or clear, job_len carries the
// service time of an arriving job
// result channel: done is high for exactly one cycle, the cycle after the
// beat was taken, with status, slot, wait_time and turnaround valid
// busy: rejects, clears and ticks that do not finish a job leave busy low;
// an admission or a finishing tick is followed by busy while the minimum
// search wave walks the cell chain (one cell a cycle) and lands in the
// selection register, and no new beat is taken until busy falls
// reset: all slots empty, no job selected, no search pending; no clearing
// pass is needed since every cell clears at once
// the receiver cannot stall: done is a strobe and is never held
module srtf_preemptive_scheduler #(
    parameter int MAX_SLOTS = srtf_pkg::MAX_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [srtf_pkg::REQ_W-1:0]        req_type,
    input  logic [srtf_pkg::BURST_W-1:0]      job_len,
    output logic                              done,
    output logic [srtf_pkg::STAT_W-1:0]       status,
    output logic [srtf_pkg::SLOT_W-1:0]       slot,
    output logic [srtf_pkg::WAIT_W-1:0]       wait_time,
    output logic [srtf_pkg::WAIT_W-1:0]       turnaround
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_SLOTS);
    // the search ends once the wave has passed every cell after the update
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_SLOTS);

    // fsm and handshake
    srtf_pkg::fsm_t state_reg, state_next;
    logic           accept;
    logic           go_search;
    logic [CNT_W-1:0] scan_reg, scan_next;

    // scheduler bookkeeping
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] running_reg, running_next;
    logic             run_valid_reg, run_valid_next;

    // result registers
    logic                         done_reg;
    srtf_pkg::status_t            status_reg, status_next;
    logic [srtf_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [srtf_pkg::WAIT_W-1:0]  wait_reg, wait_next;
    logic [srtf_pkg::WAIT_W-1:0]  tat_reg, tat_next;

    // cell chain
    srtf_pkg::cell_cmd_t          cmd;
    srtf_pkg::wave_t              wave_a [0:MAX_SLOTS];
    logic [srtf_pkg::BURST_W-1:0] rem_a    [0:MAX_SLOTS-1];
    logic [srtf_pkg::BURST_W-1:0] served_a [0:MAX_SLOTS-1];
    logic [srtf_pkg::WAIT_W-1:0]  waited_a [0:MAX_SLOTS-1];

    logic [srtf_pkg::BURST_W-1:0] run_rem;
    logic [srtf_pkg::BURST_W-1:0] run_served;
    logic [srtf_pkg::WAIT_W-1:0]  run_waited;
    logic [srtf_pkg::WAIT_W:0]    tat_sum;

    // head of the chain sees an empty wave
    assign wave_a[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLOTS; gi++)
        begin : g_cell
            srtf_cell #(
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .wave_in  (wave_a[gi]),
                .wave_out (wave_a[gi+1]),
                .rem      (rem_a[gi]),
                .served   (served_a[gi]),
                .waited   (waited_a[gi])
            );
        end
    endgenerate

    // selected job's counters, read before this beat updates them
    assign run_rem    = rem_a[running_reg];
    assign run_served = served_a[running_reg];
    assign run_waited = waited_a[running_reg];
    // turnaround of a finishing job counts the unit it runs now
    assign tat_sum    = {1'b0, run_waited} + (srtf_pkg::WAIT_W+1)'(run_served)
                        + 1'b1;

    // fsm outputs
    always_comb
    begin
        busy   = (state_reg == srtf_pkg::FSM_SEARCH);
        accept = start && (state_reg == srtf_pkg::FSM_IDLE);
    end

    // request decode
    always_comb
    begin
        cmd            = '0;
        cmd.burst      = job_len;
        cmd.sel        = srtf_pkg::SLOT_W'(running_reg);
        go_search      = 1'b0;
        count_next     = count_reg;
        status_next    = srtf_pkg::ST_REJECTED;
        slot_next      = '0;
        wait_next      = '0;
        tat_next       = '0;
        case (req_type)
            srtf_pkg::REQ_ARRIVAL:
            begin
                if (job_len != '0 && count_reg < CNT_FULL)
                begin
                    cmd.load    = accept;
                    cmd.sel     = srtf_pkg::SLOT_W'(count_reg);
                    count_next  = count_reg + 1'b1;
                    status_next = srtf_pkg::ST_ADMITTED;
                    slot_next   = srtf_pkg::SLOT_W'(count_reg);
                    go_search   = 1'b1;
                end
            end
            srtf_pkg::REQ_TICK:
            begin
                if (!run_valid_reg || run_rem == '0)
                begin
                    status_next = srtf_pkg::ST_IDLE_TCK;
                end
                else
                begin
                    cmd.tick  = accept;
                    slot_next = srtf_pkg::SLOT_W'(running_reg);
                    if (run_rem == srtf_pkg::BURST_W'(1))
                    begin
                        status_next = srtf_pkg::ST_FINISHED;
                        wait_next   = run_waited;
                        tat_next    = tat_sum[srtf_pkg::WAIT_W] ? srtf_pkg::WAIT_MAX
                                                                : tat_sum[srtf_pkg::WAIT_W-1:0];
                        go_search   = 1'b1;
                    end
                    else
                    begin
                        status_next = srtf_pkg::ST_RAN;
                    end
                end
            end
            srtf_pkg::REQ_CLEAR:
            begin
                cmd.clear   = accept;
                count_next  = '0;
                status_next = srtf_pkg::ST_CLEARED;
            end
            default:
            begin
                status_next = srtf_pkg::ST_REJECTED;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        case (state_reg)
            srtf_pkg::FSM_IDLE:
            begin
                scan_next = '0;
                if (accept && go_search)
                begin
                    state_next = srtf_pkg::FSM_SEARCH;
                end
            end
            srtf_pkg::FSM_SEARCH:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SCAN_LAST)
                begin
                    state_next = srtf_pkg::FSM_IDLE;
                    scan_next  = '0;
                end
            end
            default:
            begin
                state_next = srtf_pkg::FSM_IDLE;
                scan_next  = '0;
            end
        endcase
    end

    // selection: cleared by a clear beat, taken from the chain tail at search end
    always_comb
    begin
        running_next   = running_reg;
        run_valid_next = run_valid_reg;
        if (accept && cmd.clear)
        begin
            running_next   = '0;
            run_valid_next = 1'b0;
        end
        else if (state_reg == srtf_pkg::FSM_SEARCH && scan_reg == SCAN_LAST)
        begin
            running_next   = wave_a[MAX_SLOTS].idx[IDX_W-1:0];
            run_valid_next = wave_a[MAX_SLOTS].valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtf_pkg::FSM_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            running_reg   <= '0;
            run_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            running_reg   <= running_next;
            run_valid_reg <= run_valid_next;
            done_reg      <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            wait_reg   <= wait_next;
            tat_reg    <= tat_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign wait_time  = wait_reg;
    assign turnaround = tat_reg;

    // every taken beat yields exactly one result beat on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result beat missing after accepted command");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without an accepted command");

    // a finished job never reports more waiting than turnaround
    a_tat_covers_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == srtf_pkg::ST_FINISHED) |-> (wait_time <= turnaround))
        else $error("turnaround below waiting time");

    // outside a search the selected slot always holds unfinished work
    a_selection_live: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && run_valid_reg) |-> (run_rem != '0))
        else $error("selected slot has no remaining time");

endmodule
